FILE: rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared types and constants for the FAT12 cluster chain follower.
// ----------------------------------------------------------------------------
package fcf_pkg;

	// field widths
	localparam int CLUS_W  = 12;
	localparam int IDX_W   = 13;
	localparam int BYTE_W  = 8;
	localparam int LBA_W   = 13;
	localparam int TRACK_W = 7;
	localparam int SECT_W  = 5;

	// stream widths
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 40;
	localparam int OUT_USER_W  = 2;

	// disk geometry
	localparam int SECTOR_BYTES      = 512;
	localparam int SECTORS_PER_TRACK = 18;

	// chain decoding
	localparam logic [CLUS_W-1:0] END_MARK    = 12'hFF0;
	localparam logic [LBA_W-1:0]  DATA_OFFSET = 13'd31;
	localparam logic [BYTE_W-1:0] LO_NIBBLE   = 8'h0F;
	localparam logic [BYTE_W-1:0] HI_NIBBLE   = 8'hF0;

	// reciprocal for lba / sectors per track, one correction step after it
	localparam int               DIV_SHIFT = 19;
	localparam int               RECIP_W   = 20;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'((64'd1 << DIV_SHIFT) / SECTORS_PER_TRACK);
	localparam logic [LBA_W-1:0] SPT = LBA_W'(SECTORS_PER_TRACK);

	// table access request
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] wdata;
	} tbl_req_t;

endpackage

FILE: rtl/fcf_ram.sv
// ----------------------------------------------------------------------------
// fcf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read, data held while idle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

FILE: rtl/fcf_table.sv
// ----------------------------------------------------------------------------
// fcf_table
// Allocation table split in even and odd byte banks, so both bytes of a
// 12-bit entry come out in one read.
// ----------------------------------------------------------------------------
module fcf_table #(
	parameter int FAT_SECTORS = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fcf_pkg::tbl_req_t       req,
	output logic [fcf_pkg::BYTE_W-1:0] lo_byte,
	output logic [fcf_pkg::BYTE_W-1:0] hi_byte
);
	import fcf_pkg::*;

	localparam int TABLE_BYTES = FAT_SECTORS * SECTOR_BYTES;
	localparam int BANK_DEPTH  = TABLE_BYTES / 2;
	localparam int AW          = $clog2(BANK_DEPTH);

	logic              en;
	logic              in_table;
	logic [IDX_W:0]    addr_inc;
	logic [AW-1:0]     even_addr;
	logic [AW-1:0]     odd_addr;
	logic              even_we;
	logic              odd_we;
	logic [BYTE_W-1:0] even_rd;
	logic [BYTE_W-1:0] odd_rd;
	logic              swap_q;

	// bank steering: a read at an odd offset takes its high byte from the next even row
	always_comb begin
		en        = req.rd | req.wr;
		in_table  = ({1'b0, req.addr} < (IDX_W+1)'(TABLE_BYTES));
		addr_inc  = {1'b0, req.addr} + (IDX_W+1)'(1);
		odd_addr  = req.addr[AW:1];
		even_addr = req.rd ? addr_inc[AW:1] : req.addr[AW:1];
		even_we   = req.wr & in_table & ~req.addr[0];
		odd_we    = req.wr & in_table & req.addr[0];
	end

	fcf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_even (
		.clk   (clk),
		.en    (en),
		.we    (even_we),
		.addr  (even_addr),
		.wdata (req.wdata),
		.rdata (even_rd)
	);

	fcf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_odd (
		.clk   (clk),
		.en    (en),
		.we    (odd_we),
		.addr  (odd_addr),
		.wdata (req.wdata),
		.rdata (odd_rd)
	);

	// remember which bank holds the low byte of the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (req.rd) begin
			swap_q <= req.addr[0];
		end
	end

	assign lo_byte = swap_q ? odd_rd : even_rd;
	assign hi_byte = swap_q ? even_rd : odd_rd;

endmodule

FILE: rtl/fat12_chain_follower_unit.sv
// ----------------------------------------------------------------------------
// fat12_chain_follower_unit
// FAT12 cluster chain lookup over an on-chip copy of the allocation table.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready. s_tuser selects the kind: 0
// stores byte_value at byte_index in the table, 1 follows the cluster in
// s_tdata. Every input beat yields exactly one output beat on m_*; a table
// write yields an all-zero beat.
// A follow beat returns the next cluster of the chain (0 at end of chain),
// the data sector lba (cluster + 31) with head, track and sector, and the
// flags sector_valid and out_of_range in m_tuser.
// The result passes the stage 1 registers and the output register to m_*.
// Throughput: one beat per cycle unless m_tready stalls the output, set
// by the single read port of each table bank (entry bytes are split over
// an even and an odd bank).
// A write followed at once by a follow of the same entry sees the new byte.
// Reset clears the pipeline valids and the bank swap flag only; the table contents are undefined
// until written and must be loaded before entries are followed.
// When m_tready is low the output register holds its beat, one more beat
// fills the internal stage, and then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module fat12_chain_follower_unit #(
	parameter int FAT_SECTORS = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// byte_index, byte_value, cluster, zero fill
	input  logic [fcf_pkg::IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// next_cluster, sector_lba, chs_head, chs_track, chs_sector, zero fill
	output logic [fcf_pkg::OUT_DATA_W-1:0] m_tdata,
	// sector_valid, out_of_range
	output logic [fcf_pkg::OUT_USER_W-1:0] m_tuser
);
	import fcf_pkg::*;

	localparam int TABLE_BYTES = FAT_SECTORS * SECTOR_BYTES;
	localparam int PROD_W      = LBA_W + RECIP_W;

	// input fields
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] byte_value;
	logic [CLUS_W-1:0] cluster;
	logic              func;

	// stage 0 logic
	logic              accept;
	logic              follow_ok;
	logic [IDX_W-1:0]  entry_off;
	logic [IDX_W:0]    entry_end;
	logic              beyond;
	logic [LBA_W-1:0]  lba;
	logic [PROD_W-1:0] prod;
	tbl_req_t          req;
	logic [BYTE_W-1:0] lo_byte;
	logic [BYTE_W-1:0] hi_byte;

	// stage 1 registers
	logic              valid_s1;
	logic              sv_s1;
	logic              oor_s1;
	logic              odd_s1;
	logic [LBA_W-1:0]  lba_s1;
	logic [LBA_W-1:0]  q0_s1;

	// stage 1 logic
	logic              out_adv;
	logic [LBA_W-1:0]  rem_raw;
	logic              fix;
	logic [LBA_W-1:0]  quot;
	logic [LBA_W-1:0]  rem;
	logic [CLUS_W-1:0] entry;
	logic [CLUS_W-1:0] next_val;

	// output registers
	logic              m_tvalid_q;
	logic [CLUS_W-1:0] next_q;
	logic              sv_q;
	logic [LBA_W-1:0]  lba_q;
	logic              head_q;
	logic [TRACK_W-1:0] track_q;
	logic [SECT_W-1:0] sect_q;
	logic              oor_q;

	assign byte_index = s_tdata[IDX_W-1:0];
	assign byte_value = s_tdata[IDX_W+BYTE_W-1:IDX_W];
	assign cluster    = s_tdata[IDX_W+BYTE_W+CLUS_W-1:IDX_W+BYTE_W];
	assign func       = s_tuser;

	// handshake: stage 1 moves whenever the output register frees up
	assign out_adv  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || out_adv;
	assign accept   = s_tvalid && s_tready;

	// entry offset cluster*3/2, lba and first reciprocal estimate
	always_comb begin
		follow_ok = func && (cluster != '0) && (cluster < END_MARK);
		entry_off = IDX_W'({1'b0, cluster} + {2'b0, cluster[CLUS_W-1:1]});
		entry_end = {1'b0, entry_off} + (IDX_W+1)'(1);
		beyond    = entry_end >= (IDX_W+1)'(TABLE_BYTES);
		lba       = LBA_W'(cluster) + DATA_OFFSET;
		prod      = PROD_W'(lba) * PROD_W'(DIV_RECIP);
	end

	// table request: reads only for entries that lie inside the table
	always_comb begin
		req.rd    = accept && follow_ok && !beyond;
		req.wr    = accept && !func;
		req.addr  = func ? entry_off : byte_index;
		req.wdata = byte_value;
	end

	fcf_table #(
		.FAT_SECTORS (FAT_SECTORS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.lo_byte (lo_byte),
		.hi_byte (hi_byte)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sv_s1  <= follow_ok;
			oor_s1 <= beyond;
			odd_s1 <= cluster[0];
			lba_s1 <= lba;
			q0_s1  <= prod[DIV_SHIFT+LBA_W-1:DIV_SHIFT];
		end
	end

	// division correction and entry unpacking
	always_comb begin
		rem_raw = lba_s1 - LBA_W'(q0_s1 * SPT);
		fix     = rem_raw >= SPT;
		quot    = fix ? q0_s1 + LBA_W'(1) : q0_s1;
		rem     = fix ? rem_raw - SPT : rem_raw;
		if (odd_s1) begin
			entry = {hi_byte, 4'((lo_byte & HI_NIBBLE) >> 4)};
		end else begin
			entry = {4'(hi_byte & LO_NIBBLE), lo_byte};
		end
		if (oor_s1 || entry >= END_MARK) begin
			next_val = '0;
		end else begin
			next_val = entry;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_adv) begin
			m_tvalid_q <= valid_s1;
		end
	end

	// output payload, all zero when no sector was named
	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			if (sv_s1) begin
				next_q  <= next_val;
				sv_q    <= 1'b1;
				lba_q   <= lba_s1;
				head_q  <= quot[0];
				track_q <= quot[TRACK_W:1];
				sect_q  <= SECT_W'(rem + LBA_W'(1));
				oor_q   <= oor_s1;
			end else begin
				next_q  <= '0;
				sv_q    <= 1'b0;
				lba_q   <= '0;
				head_q  <= 1'b0;
				track_q <= '0;
				sect_q  <= '0;
				oor_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, sect_q, track_q, head_q, lba_q, next_q};
	assign m_tuser  = {oor_q, sv_q};

endmodule
